[src/assert_macros.svh]
// assertion macros shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

[src/uihp_pkg.sv]
// types and constants of the ipv4 host parser
`timescale 1ns / 1ps

package uihp_pkg;

    // one character request
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    // one parse result
    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  status;
    } t_out;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } t_base;

    // decoded view of one character
    typedef struct packed {
        logic [3:0] digit;
        logic       is_digit;
        logic       is_dot;
        logic       is_x;
    } t_char_info;

    // finished host string, waiting for the result stage
    typedef struct packed {
        logic [31:0] address_sum;
        logic [31:0] pending_part;
        logic [2:0]  parts_counted;
        logic        seen_non_numeric;
        logic        seen_out_of_range;
    } t_snap;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_TOO_MANY    = 2'd1;
    localparam logic [1:0] ST_NON_NUMERIC = 2'd2;
    localparam logic [1:0] ST_RANGE       = 2'd3;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_X_LO = 8'h78;
    localparam logic [7:0] CHAR_X_UP = 8'h58;

    localparam logic [2:0]  PARTS_SAT  = 3'd5;
    localparam logic [2:0]  PARTS_IPV4 = 3'd4;
    localparam logic [31:0] BYTE_MAX   = 32'd255;

endpackage

[src/url_ipv4_host_parser.sv]
// top level of the url ipv4 host parser: input register, parse state, result stage
// a result passes from the input register through the string snapshot into the output register
// throughput: one character per cycle while no last character stalls; the accumulate step reads only its own registers
// a last character stalls only while the string snapshot and output register are both full and the output is not read
// reset: i_rst_n synchronous active low clears all parse state and every valid flag
`timescale 1ns / 1ps
`include "assert_macros.svh"

module url_ipv4_host_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // character requests
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  uihp_pkg::t_in   i_in_req,
    // parse results
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output uihp_pkg::t_out  o_out_res
);
    import uihp_pkg::*;

    // input register holding one character request
    logic  r_in_valid, n_in_valid;
    t_in   r_in,       n_in;

    logic  step;        // accumulate stage consumes the held character
    logic  snap_valid;  // a finished string waits for the result stage
    logic  snap_take;   // result stage takes that string this cycle
    logic  snap_free;   // snapshot slot can accept a new string this cycle
    t_snap snap;

    // the snapshot drains whenever the output register is empty or being read
    assign snap_take = snap_valid && (!o_out_valid || i_out_ready);
    assign snap_free = !snap_valid || snap_take;

    // only a last character needs the snapshot slot; others always step
    assign step       = r_in_valid && (!r_in.last_char || snap_free);
    assign o_in_ready = !r_in_valid || step;

    always_comb begin
        n_in_valid = r_in_valid;
        n_in       = r_in;
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
            n_in       = i_in_req;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
    end

    // part accumulation and string close
    uihp_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_char       (r_in),
        .i_snap_take  (snap_take),
        .o_snap       (snap),
        .o_snap_valid (snap_valid)
    );

    // status selection and output register
    uihp_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap      (snap),
        .i_load      (snap_take),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

    `ASSERT_PROP(a_err_addr_zero, o_out_valid && (o_out_res.status != ST_OK) |-> (o_out_res.address == '0), "address nonzero on error status")
    `ASSERT_PROP(a_snap_held, snap_valid && !snap_take |=> snap_valid, "pending string lost before output")

endmodule

[src/uihp_digit.sv]
// character classifier: digit value in a given radix, dot and x detection
`timescale 1ns / 1ps

module uihp_digit (
    input  logic [7:0]          i_char_code,
    input  uihp_pkg::t_base     i_base,
    output uihp_pkg::t_char_info o_info
);
    import uihp_pkg::*;

    always_comb begin
        o_info          = '0;
        o_info.is_dot   = (i_char_code == CHAR_DOT);
        o_info.is_x     = (i_char_code == CHAR_X_LO) || (i_char_code == CHAR_X_UP);
        case (i_base)
            BASE_OCT: begin
                if (i_char_code inside {[8'h30:8'h37]}) begin
                    o_info.digit    = i_char_code[3:0];
                    o_info.is_digit = 1'b1;
                end
            end
            BASE_HEX: begin
                if (i_char_code inside {[8'h30:8'h39]}) begin
                    o_info.digit    = i_char_code[3:0];
                    o_info.is_digit = 1'b1;
                end else if (i_char_code inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
                    // 'a' and 'A' end in 1, so add nine
                    o_info.digit    = i_char_code[3:0] + 4'd9;
                    o_info.is_digit = 1'b1;
                end
            end
            default: begin
                if (i_char_code inside {[8'h30:8'h39]}) begin
                    o_info.digit    = i_char_code[3:0];
                    o_info.is_digit = 1'b1;
                end
            end
        endcase
    end

endmodule

[src/uihp_accum.sv]
// per-character parse state: part accumulation, part close and string snapshot
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uihp_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  uihp_pkg::t_in   i_char,
    input  logic            i_snap_take,
    output uihp_pkg::t_snap o_snap,
    output logic            o_snap_valid
);
    import uihp_pkg::*;

    logic [31:0] r_address_sum,       n_address_sum;
    logic [31:0] r_pending_part,      n_pending_part;
    logic [31:0] r_part_number,       n_part_number;
    logic        r_part_too_big,      n_part_too_big;
    logic [1:0]  r_part_chars,        n_part_chars;
    t_base       r_part_base,         n_part_base;
    logic        r_part_bad,          n_part_bad;
    logic [2:0]  r_parts_counted,     n_parts_counted;
    logic        r_seen_non_numeric,  n_seen_non_numeric;
    logic        r_seen_out_of_range, n_seen_out_of_range;
    t_snap       r_snap,              n_snap;
    logic        r_snap_valid,        n_snap_valid;

    logic        first_zero;
    t_base       eff_base;
    t_char_info  info;
    logic [35:0] wide;
    logic [35:0] scaled;

    // part after this character
    logic [31:0] p_num;
    logic        p_big;
    logic [1:0]  p_chars;
    t_base       p_base;
    logic        p_bad;

    // state after closing the part
    logic [31:0] f_sum;
    logic        f_nonnum;
    logic        f_oor;
    logic [2:0]  f_pc;
    logic        finish;

    // second char of a part that began with a lone zero picks octal or hex
    assign first_zero = (r_part_chars == 2'd1) && !r_part_bad && (r_part_number == '0);
    assign eff_base   = first_zero ? BASE_OCT : r_part_base;

    uihp_digit u_digit (
        .i_char_code (i_char.char_code),
        .i_base      (eff_base),
        .o_info      (info)
    );

    always_comb begin
        case (eff_base)
            BASE_OCT: scaled = {1'b0, r_part_number, 3'b000};
            BASE_HEX: scaled = {r_part_number, 4'b0000};
            default:  scaled = {1'b0, r_part_number, 3'b000}
                             + {3'b000, r_part_number, 1'b0};
        endcase
        wide = scaled + {32'd0, info.digit};
    end

    always_comb begin
        p_num   = r_part_number;
        p_big   = r_part_too_big;
        p_chars = r_part_chars;
        p_base  = r_part_base;
        p_bad   = r_part_bad;
        if (!info.is_dot) begin
            p_chars = (r_part_chars == 2'd2) ? 2'd2 : r_part_chars + 2'd1;
            if (r_part_chars == 2'd0) begin
                p_base = BASE_DEC;
            end else if (first_zero) begin
                p_base = info.is_x ? BASE_HEX : BASE_OCT;
            end
            if (!(first_zero && info.is_x)) begin
                if (!info.is_digit) begin
                    p_bad = 1'b1;
                end else if (!r_part_too_big) begin
                    if (wide[35:32] != 4'd0) begin
                        p_big = 1'b1;
                    end else begin
                        p_num = wide[31:0];
                    end
                end
            end
        end
    end

    // close the part: fold the previously completed part into its byte
    always_comb begin
        finish   = info.is_dot || i_char.last_char;
        f_sum    = r_address_sum;
        f_oor    = r_seen_out_of_range;
        f_nonnum = r_seen_non_numeric || (p_chars == 2'd0) || p_bad || p_big;
        f_pc     = (r_parts_counted == PARTS_SAT) ? PARTS_SAT : r_parts_counted + 3'd1;
        if (r_parts_counted != 3'd0) begin
            if (r_pending_part > BYTE_MAX) begin
                f_oor = 1'b1;
            end else begin
                case (r_parts_counted)
                    3'd1:    f_sum = r_address_sum + {r_pending_part[7:0], 24'd0};
                    3'd2:    f_sum = r_address_sum + {8'd0, r_pending_part[7:0], 16'd0};
                    3'd3:    f_sum = r_address_sum + {16'd0, r_pending_part[7:0], 8'd0};
                    3'd4:    f_sum = r_address_sum + {24'd0, r_pending_part[7:0]};
                    default: f_sum = r_address_sum;
                endcase
            end
        end
    end

    always_comb begin
        n_address_sum       = r_address_sum;
        n_pending_part      = r_pending_part;
        n_part_number       = r_part_number;
        n_part_too_big      = r_part_too_big;
        n_part_chars        = r_part_chars;
        n_part_base         = r_part_base;
        n_part_bad          = r_part_bad;
        n_parts_counted     = r_parts_counted;
        n_seen_non_numeric  = r_seen_non_numeric;
        n_seen_out_of_range = r_seen_out_of_range;
        n_snap              = r_snap;
        n_snap_valid        = r_snap_valid && !i_snap_take;
        if (i_step) begin
            if (i_char.last_char) begin
                n_snap.address_sum       = f_sum;
                n_snap.pending_part      = p_num;
                n_snap.parts_counted     = f_pc;
                n_snap.seen_non_numeric  = f_nonnum;
                n_snap.seen_out_of_range = f_oor;
                n_snap_valid             = 1'b1;
                n_address_sum            = '0;
                n_pending_part           = '0;
                n_parts_counted          = '0;
                n_seen_non_numeric       = 1'b0;
                n_seen_out_of_range      = 1'b0;
                n_part_number            = '0;
                n_part_too_big           = 1'b0;
                n_part_chars             = '0;
                n_part_base              = BASE_DEC;
                n_part_bad               = 1'b0;
            end else if (finish) begin
                n_address_sum       = f_sum;
                n_pending_part      = p_num;
                n_parts_counted     = f_pc;
                n_seen_non_numeric  = f_nonnum;
                n_seen_out_of_range = f_oor;
                n_part_number       = '0;
                n_part_too_big      = 1'b0;
                n_part_chars        = '0;
                n_part_base         = BASE_DEC;
                n_part_bad          = 1'b0;
            end else begin
                n_part_number  = p_num;
                n_part_too_big = p_big;
                n_part_chars   = p_chars;
                n_part_base    = p_base;
                n_part_bad     = p_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_sum       <= '0;
            r_pending_part      <= '0;
            r_part_number       <= '0;
            r_part_too_big      <= 1'b0;
            r_part_chars        <= '0;
            r_part_base         <= BASE_DEC;
            r_part_bad          <= 1'b0;
            r_parts_counted     <= '0;
            r_seen_non_numeric  <= 1'b0;
            r_seen_out_of_range <= 1'b0;
            r_snap_valid        <= 1'b0;
        end else begin
            r_address_sum       <= n_address_sum;
            r_pending_part      <= n_pending_part;
            r_part_number       <= n_part_number;
            r_part_too_big      <= n_part_too_big;
            r_part_chars        <= n_part_chars;
            r_part_base         <= n_part_base;
            r_part_bad          <= n_part_bad;
            r_parts_counted     <= n_parts_counted;
            r_seen_non_numeric  <= n_seen_non_numeric;
            r_seen_out_of_range <= n_seen_out_of_range;
            r_snap_valid        <= n_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
    end

    assign o_snap       = r_snap;
    assign o_snap_valid = r_snap_valid;

    `ASSERT_NEVER(a_parts_sat, r_parts_counted > PARTS_SAT, "part count above saturation")
    `ASSERT_PROP(a_clear_after_last, i_step && i_char.last_char |=> (r_parts_counted == '0) && (r_part_chars == '0) && !r_seen_non_numeric, "state not cleared after last char")

endmodule

[src/uihp_result.sv]
// result stage: status priority, final address add and output register
`timescale 1ns / 1ps

module uihp_result (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  uihp_pkg::t_snap  i_snap,
    input  logic             i_load,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output uihp_pkg::t_out   o_out_res
);
    import uihp_pkg::*;

    logic       r_out_valid, n_out_valid;
    t_out       r_out_res,   n_out_res;
    logic       last_too_big;

    // last part must fit in the bytes the earlier parts left
    always_comb begin
        case (i_snap.parts_counted)
            3'd2:    last_too_big = (i_snap.pending_part[31:24] != 8'd0);
            3'd3:    last_too_big = (i_snap.pending_part[31:16] != 16'd0);
            3'd4:    last_too_big = (i_snap.pending_part[31:8] != 24'd0);
            default: last_too_big = 1'b0;
        endcase
    end

    always_comb begin
        n_out_res = r_out_res;
        if (i_load) begin
            n_out_res.address = '0;
            if (i_snap.parts_counted > PARTS_IPV4) begin
                n_out_res.status = ST_TOO_MANY;
            end else if (i_snap.seen_non_numeric) begin
                n_out_res.status = ST_NON_NUMERIC;
            end else if (i_snap.seen_out_of_range || last_too_big) begin
                n_out_res.status = ST_RANGE;
            end else begin
                n_out_res.status  = ST_OK;
                n_out_res.address = i_snap.address_sum + i_snap.pending_part;
            end
        end
        if (i_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_res <= n_out_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule
